FILE: rtl/gf2_128_field_unit_macros.svh
// Assertion helpers for the field unit
`ifndef GF2_128_FIELD_UNIT_MACROS_SVH
`define GF2_128_FIELD_UNIT_MACROS_SVH

// same-cycle implication
`define GFU_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gf2_128_field_unit: assertion failed");

// next-cycle implication
`define GFU_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gf2_128_field_unit: assertion failed");

`endif

FILE: rtl/gfu_pkg.sv
package gfu_pkg;

  localparam int unsigned ELEM_W  = 128;
  localparam int unsigned HALF_W  = 64;
  localparam int unsigned DIGIT_W = 32;
  localparam int unsigned INV_STEPS = 7;

  localparam logic [7:0] RED_POLY = 8'b1000_0111;

  localparam logic [1:0] OP_MUL = 2'd0;
  localparam logic [1:0] OP_POW = 2'd1;
  localparam logic [1:0] OP_INV = 2'd2;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [HALF_W-1:0] a_hi;
    logic [HALF_W-1:0] a_lo;
    logic [HALF_W-1:0] b_hi;
    logic [HALF_W-1:0] b_lo;
    logic [HALF_W-1:0] exponent;
  } gfu_req_t;

  typedef struct packed {
    logic [HALF_W-1:0] result_hi;
    logic [HALF_W-1:0] result_lo;
    logic              zero_inverse;
  } gfu_rsp_t;

endpackage

FILE: rtl/gf2_128_field_unit.sv
// GF(2^128) arithmetic unit, polynomial x^128+x^7+x^2+x+1, plain bit order (bit k of
// {hi,lo} is the coefficient of x^k). One request at a time: in_ready_o is high only
// while the unit is idle, and the result stays on out_data_o until it is taken. All
// work runs through one shared 128 x 32 carry-less multiply-and-reduce step, so one
// field multiply runs that step once per 32-bit digit, and power and inverse pass
// through a sequencing state between field multiplies. Power does one squaring per
// exponent bit below the top set bit and one multiply per set bit, and a zero base
// returns zero without any field multiply; inverse does 127 squarings and 13
// multiplies, and a zero operand returns zero with zero_inverse set. Selector three
// returns zero.
`include "gf2_128_field_unit_macros.svh"

module gf2_128_field_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  gfu_pkg::gfu_req_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output gfu_pkg::gfu_rsp_t out_data_o
);
  import gfu_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PLAN = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  localparam logic [2:0] PH_FINAL = 3'd0;
  localparam logic [2:0] PH_PACC  = 3'd1;
  localparam logic [2:0] PH_PSQ   = 3'd2;
  localparam logic [2:0] PH_ISQ   = 3'd3;
  localparam logic [2:0] PH_IRUN  = 3'd4;
  localparam logic [2:0] PH_IOUT  = 3'd5;

  localparam logic [1:0] SUB_SQ   = 2'd0;
  localparam logic [1:0] SUB_RUN  = 2'd1;
  localparam logic [1:0] SUB_OUT  = 2'd2;
  localparam logic [1:0] SUB_NEXT = 2'd3;

  localparam int unsigned DCNT_W = $clog2(ELEM_W / DIGIT_W);
  localparam logic [DCNT_W-1:0] DCNT_LAST = DCNT_W'(ELEM_W / DIGIT_W - 1);
  localparam logic [2:0] LAST_STEP = 3'(INV_STEPS - 1);

  function automatic logic [ELEM_W-1:0] mul_step(input logic [ELEM_W-1:0]  z,
                                                 input logic [ELEM_W-1:0]  x,
                                                 input logic [DIGIT_W-1:0] d);
    logic [ELEM_W+DIGIT_W-1:0] s;
    logic [DIGIT_W-1:0]        h;
    logic [DIGIT_W+7-1:0]      f;
    s = {z, {DIGIT_W{1'b0}}};
    for (int i = 0; i < DIGIT_W; i++) begin
      if (d[i]) begin
        s = s ^ ({{DIGIT_W{1'b0}}, x} << i);
      end
    end
    h = s[ELEM_W+DIGIT_W-1:ELEM_W];
    f = '0;
    for (int j = 0; j < 8; j++) begin
      if (RED_POLY[j]) begin
        f = f ^ ({7'b0, h} << j);
      end
    end
    return s[ELEM_W-1:0] ^ {{(ELEM_W-DIGIT_W-7){1'b0}}, f};
  endfunction

  logic [1:0]        state_q, state_d;
  logic [1:0]        op_q, op_d;
  logic [DCNT_W-1:0] dcnt_q, dcnt_d;
  logic [2:0]        phase_q, phase_d;
  logic [1:0]        sub_q, sub_d;
  logic [2:0]        step_q, step_d;
  logic [6:0]        n_q, n_d;

  logic [ELEM_W-1:0] x_q, x_d, y_q, y_d, z_q, z_d;
  logic [ELEM_W-1:0] a_q, a_d, b_q, b_d, t_q, t_d, res_q, res_d;
  logic [HALF_W-1:0] e_q, e_d;
  logic              flag_q, flag_d;

  logic [ELEM_W-1:0] mz;
  logic [ELEM_W-1:0] in_a;
  logic              start_en;
  logic [ELEM_W-1:0] start_x, start_y;
  logic [2:0]        start_ph;

  assign in_a = {in_data_i.a_hi, in_data_i.a_lo};
  assign mz   = mul_step(z_q, x_q, y_q[ELEM_W-1:ELEM_W-DIGIT_W]);

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    dcnt_d   = dcnt_q;
    phase_d  = phase_q;
    sub_d    = sub_q;
    step_d   = step_q;
    n_d      = n_q;
    x_d      = x_q;
    y_d      = y_q;
    z_d      = z_q;
    a_d      = a_q;
    b_d      = b_q;
    t_d      = t_q;
    e_d      = e_q;
    res_d    = res_q;
    flag_d   = flag_q;
    start_en = 1'b0;
    start_x  = a_q;
    start_y  = a_q;
    start_ph = PH_FINAL;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d   = in_data_i.req_type;
          flag_d = 1'b0;
          res_d  = '0;
          a_d    = in_a;
          unique case (in_data_i.req_type)
            OP_MUL: begin
              start_en = 1'b1;
              start_x  = in_a;
              start_y  = {in_data_i.b_hi, in_data_i.b_lo};
              start_ph = PH_FINAL;
            end
            OP_POW: begin
              if (in_a == '0) begin
                state_d = ST_OUT;
              end else begin
                b_d     = ELEM_W'(1);
                e_d     = in_data_i.exponent;
                state_d = ST_PLAN;
              end
            end
            OP_INV: begin
              if (in_a == '0) begin
                flag_d  = 1'b1;
                state_d = ST_OUT;
              end else begin
                t_d     = in_a;
                n_d     = '0;
                step_d  = '0;
                sub_d   = SUB_SQ;
                state_d = ST_PLAN;
              end
            end
            default: begin
              state_d = ST_OUT;
            end
          endcase
        end
      end
      ST_PLAN: begin
        if (op_q == OP_POW) begin
          if (e_q == '0) begin
            res_d   = b_q;
            state_d = ST_OUT;
          end else if (e_q[0]) begin
            start_en = 1'b1;
            start_x  = b_q;
            start_y  = a_q;
            start_ph = PH_PACC;
          end else begin
            start_en = 1'b1;
            start_x  = a_q;
            start_y  = a_q;
            start_ph = PH_PSQ;
          end
        end else begin
          unique case (sub_q)
            SUB_SQ: begin
              if (n_q == (7'd1 << step_q)) begin
                sub_d = SUB_RUN;
              end else begin
                start_en = 1'b1;
                start_x  = t_q;
                start_y  = t_q;
                start_ph = PH_ISQ;
              end
            end
            SUB_RUN: begin
              start_en = 1'b1;
              start_x  = a_q;
              start_y  = t_q;
              start_ph = PH_IRUN;
            end
            SUB_OUT: begin
              if (step_q == '0) begin
                b_d   = t_q;
                sub_d = SUB_NEXT;
              end else begin
                start_en = 1'b1;
                start_x  = b_q;
                start_y  = t_q;
                start_ph = PH_IOUT;
              end
            end
            SUB_NEXT: begin
              if (step_q == LAST_STEP) begin
                res_d   = b_q;
                state_d = ST_OUT;
              end else begin
                step_d = step_q + 3'd1;
                t_d    = a_q;
                n_d    = '0;
                sub_d  = SUB_SQ;
              end
            end
            default: ;
          endcase
        end
      end
      ST_MUL: begin
        z_d    = mz;
        y_d    = y_q << DIGIT_W;
        dcnt_d = dcnt_q + DCNT_W'(1);
        if (dcnt_q == DCNT_LAST) begin
          state_d = ST_PLAN;
          unique case (phase_q)
            PH_FINAL: begin
              res_d   = mz;
              state_d = ST_OUT;
            end
            PH_PACC: begin
              b_d    = mz;
              e_d[0] = 1'b0;
            end
            PH_PSQ: begin
              a_d = mz;
              e_d = e_q >> 1;
            end
            PH_ISQ: begin
              t_d = mz;
              n_d = n_q + 7'd1;
            end
            PH_IRUN: begin
              a_d   = mz;
              sub_d = SUB_OUT;
            end
            PH_IOUT: begin
              b_d   = mz;
              sub_d = SUB_NEXT;
            end
            default: ;
          endcase
        end
      end
      ST_OUT: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (start_en) begin
      x_d     = start_x;
      y_d     = start_y;
      z_d     = '0;
      dcnt_d  = '0;
      phase_d = start_ph;
      state_d = ST_MUL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_MUL;
      dcnt_q  <= '0;
      phase_q <= PH_FINAL;
      sub_q   <= SUB_SQ;
      step_q  <= '0;
      n_q     <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      dcnt_q  <= dcnt_d;
      phase_q <= phase_d;
      sub_q   <= sub_d;
      step_q  <= step_d;
      n_q     <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    a_q    <= a_d;
    b_q    <= b_d;
    t_q    <= t_d;
    e_q    <= e_d;
    res_q  <= res_d;
    flag_q <= flag_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign out_data_o.result_hi    = res_q[ELEM_W-1:HALF_W];
  assign out_data_o.result_lo    = res_q[HALF_W-1:0];
  assign out_data_o.zero_inverse = flag_q;

  `GFU_ASSERT_IMP(a_flag_zero_res, out_valid_o && flag_q, res_q == '0 && op_q == OP_INV)
  `GFU_ASSERT_IMP(a_ready_excl, out_valid_o, !in_ready_o)
  `GFU_ASSERT_NXT(a_accept_busy, in_valid_i && in_ready_o, !in_ready_o)
  `GFU_ASSERT_NXT(a_mul_ends, state_q == ST_MUL && dcnt_q == DCNT_LAST, state_q != ST_MUL)

endmodule
